// ----- hw/rtl/deq_pkg.sv -----
// Shared codes and types of the double-ended queue unit.
package deq_pkg;

  // Request codes; the remaining two codes of the field do nothing.
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_REAR  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_REAR   = 3'd3;
  localparam logic [2:0] FUNC_PEEK_FRONT = 3'd4;
  localparam logic [2:0] FUNC_PEEK_REAR  = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } ctrl_state_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic load;
  } deq_cmd_t;

endpackage

// ----- hw/rtl/deq_in_if.sv -----
// Request channel of the double-ended queue unit.
interface deq_in_if #(
  parameter int unsigned DATA_WIDTH = 8
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            func;
  logic [DATA_WIDTH-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

// ----- hw/rtl/deq_out_if.sv -----
// Response channel of the double-ended queue unit.
interface deq_out_if #(
  parameter int unsigned DATA_WIDTH  = 8,
  parameter int unsigned COUNT_WIDTH = 5
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [DATA_WIDTH-1:0]  read_value;
  logic [COUNT_WIDTH-1:0] fill_count;

  modport source (output valid, output status, output read_value, output fill_count,
                  input ready);
  modport sink (input valid, input status, input read_value, input fill_count,
                output ready);
endinterface

// ----- hw/rtl/deq_ctrl.sv -----
// Handshake controller of the double-ended queue unit.
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_cmd_t cmd_o
);

  deq_pkg::ctrl_state_e state_q, state_d;

  assign in_ready_o  = (state_q == deq_pkg::ST_IDLE);
  assign out_valid_o = (state_q == deq_pkg::ST_RESP);
  assign cmd_o.load  = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      deq_pkg::ST_IDLE: begin
        if (cmd_o.load) state_d = deq_pkg::ST_RESP;
      end
      deq_pkg::ST_RESP: begin
        // hold the result until the receiver takes the beat
        if (out_ready_i) state_d = deq_pkg::ST_IDLE;
      end
      default: state_d = deq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/deq_datapath.sv -----
// Slot memory, positions, count and result registers of the double-ended queue.
module deq_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 8,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  deq_pkg::deq_cmd_t     cmd_i,
  input  logic [2:0]            func_i,
  input  logic [DATA_WIDTH-1:0] push_value_i,
  output logic [1:0]            status_o,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [CNT_W-1:0]      fill_count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(DEPTH - 1);
  localparam logic [PtrW-1:0]  ZeroPtr = '0;
  localparam logic [PtrW-1:0]  OnePtr  = PtrW'(1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] OneCnt  = CNT_W'(1);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];

  logic [PtrW-1:0]  front_q, front_d, rear_q, rear_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PtrW-1:0]  front_prev, front_next, rear_prev, rear_next;
  logic [PtrW-1:0]  addr;
  logic             wr_en, rd_ok;
  logic [1:0]       status_d;

  logic [1:0]            status_q;
  logic                  rd_ok_q;
  logic [DATA_WIDTH-1:0] rdata_q;

  assign front_prev = (front_q == ZeroPtr) ? LastPtr : front_q - OnePtr;
  assign front_next = (front_q == LastPtr) ? ZeroPtr : front_q + OnePtr;
  assign rear_prev  = (rear_q == ZeroPtr) ? LastPtr : rear_q - OnePtr;
  assign rear_next  = (rear_q == LastPtr) ? ZeroPtr : rear_q + OnePtr;

  always_comb begin
    logic is_push, is_read, full, empty;
    is_push  = (func_i == deq_pkg::FUNC_PUSH_FRONT) || (func_i == deq_pkg::FUNC_PUSH_REAR);
    is_read  = (func_i == deq_pkg::FUNC_POP_FRONT) || (func_i == deq_pkg::FUNC_POP_REAR) ||
               (func_i == deq_pkg::FUNC_PEEK_FRONT) || (func_i == deq_pkg::FUNC_PEEK_REAR);
    full     = (count_q == FullCnt);
    empty    = (count_q == '0);
    front_d  = front_q;
    rear_d   = rear_q;
    count_d  = count_q;
    addr     = front_q;
    wr_en    = 1'b0;
    rd_ok    = 1'b0;
    status_d = deq_pkg::STATUS_OK;
    if (is_push && full) begin
      status_d = deq_pkg::STATUS_FULL;
    end else if (is_read && empty) begin
      status_d = deq_pkg::STATUS_EMPTY;
    end else begin
      case (func_i)
        deq_pkg::FUNC_PUSH_FRONT: begin
          addr    = front_prev;
          front_d = front_prev;
          wr_en   = 1'b1;
          count_d = count_q + OneCnt;
        end
        deq_pkg::FUNC_PUSH_REAR: begin
          addr    = rear_q;
          rear_d  = rear_next;
          wr_en   = 1'b1;
          count_d = count_q + OneCnt;
        end
        deq_pkg::FUNC_POP_FRONT: begin
          addr    = front_q;
          front_d = front_next;
          rd_ok   = 1'b1;
          count_d = count_q - OneCnt;
        end
        deq_pkg::FUNC_POP_REAR: begin
          addr    = rear_prev;
          rear_d  = rear_prev;
          rd_ok   = 1'b1;
          count_d = count_q - OneCnt;
        end
        deq_pkg::FUNC_PEEK_FRONT: begin
          addr  = front_q;
          rd_ok = 1'b1;
        end
        deq_pkg::FUNC_PEEK_REAR: begin
          addr  = rear_prev;
          rd_ok = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.load) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
    end
  end

  // Single-port slot memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (wr_en) mem_q[addr] <= push_value_i;
      rdata_q  <= mem_q[addr];
      rd_ok_q  <= rd_ok;
      status_q <= status_d;
    end
  end

  assign status_o     = status_q;
  assign read_value_o = rd_ok_q ? rdata_q : '0;
  assign fill_count_o = count_q;

endmodule

// ----- hw/rtl/double_ended_queue_unit.sv -----
// Double-ended queue unit: bounded deque of data words on a circular slot memory.
//
// Requests arrive on in_i (func, push_value); every request yields exactly one
// response beat on out_o (status, read_value, fill_count). Both channels use a
// valid/ready handshake; a beat moves when valid and ready are high at a clock edge.
// func: push front, push rear, pop front, pop rear, peek front, peek rear.
// A push to a full deque answers full, a pop or peek on an empty one answers
// empty; neither changes the contents. read_value is zero unless a word was read.
// The response is valid in the cycle after the request is taken.
// The unit handles one request at a time and takes no new one until the response
// has been taken; the slot memory is accessed once at the acceptance edge and its
// registered read data forms the response in the next cycle.
// While the receiver stalls, the response is held and no new request is taken.
// Reset empties the deque (positions and count to zero); slot contents are
// left as they are and are only read after being written.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  deq_pkg::deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CntW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (in_i.func),
    .push_value_i (in_i.push_value),
    .status_o     (out_o.status),
    .read_value_o (out_o.read_value),
    .fill_count_o (out_o.fill_count)
  );

endmodule
